>>> rtl/lsce_pkg.sv
package lsce_pkg;

  // sample and output formats
  localparam int SAMPLE_BITS = 12;
  localparam int FRAC_BITS   = 8;
  localparam int NSENS       = 5;
  localparam int OUT_W       = 15;

  // calibration: s = 233<<GQ + gain*(adc - dark), gain = round(3037*2^GQ / D)
  localparam int GQ       = 12;
  localparam int GAIN_W   = 13;
  localparam int CAL_REF  = 3037;
  localparam int CAL_D0   = 3154;
  localparam int CAL_D1   = 3028;
  localparam int CAL_D2   = 3021;
  localparam int CAL_D3   = 3068;
  localparam int CAL_D4   = 3068;
  localparam int GAIN0    = (CAL_REF * (1 << GQ) * 2 + CAL_D0) / (2 * CAL_D0);
  localparam int GAIN1    = (CAL_REF * (1 << GQ) * 2 + CAL_D1) / (2 * CAL_D1);
  localparam int GAIN2    = (CAL_REF * (1 << GQ) * 2 + CAL_D2) / (2 * CAL_D2);
  localparam int GAIN3    = (CAL_REF * (1 << GQ) * 2 + CAL_D3) / (2 * CAL_D3);
  localparam int GAIN4    = (CAL_REF * (1 << GQ) * 2 + CAL_D4) / (2 * CAL_D4);
  localparam int GAIN_TAB [0:NSENS-1] = '{GAIN0, GAIN1, GAIN2, GAIN3, GAIN4};
  localparam int DARK_TAB [0:NSENS-1] = '{235, 230, 226, 234, 240};
  localparam int CAL_BIAS = 233 * (1 << GQ);

  // centroid weights and bias removal: (10000*num - 6986*den) / (7703*den)
  localparam int W_OUTER = 34;
  localparam int W_INNER = 17;
  localparam int K_NUM   = 10000;
  localparam int K_BIAS  = 6986;
  localparam int K_DIV   = 7703;

  // datapath widths
  localparam int CAL_W = SAMPLE_BITS + 1 + GAIN_W + 1;
  localparam int NUM_W = CAL_W + 8;
  localparam int DEN_W = CAL_W + 3;
  localparam int TOP_W = NUM_W + 15;
  localparam int BOT_W = DEN_W + 13;
  localparam int DVD_W = TOP_W + FRAC_BITS + 1;
  localparam int TQ_W  = OUT_W + 2;
  localparam int HI_W  = DVD_W - TQ_W;
  localparam int CMP_W = (HI_W > BOT_W) ? HI_W + 1 : BOT_W + 1;
  localparam int MAG_LIM = 1 << (OUT_W - 1);

  // queue between front and back (depth a power of two)
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
    logic                    pos;
  } q_item_t;

  typedef struct packed {
    logic s1_vld;
    logic s2_vld;
  } front_stat_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
  } queue_stat_t;

endpackage

>>> rtl/lsce_front.sv
module lsce_front (
  input  logic                                                  clk,
  input  logic                                                  rst_n,
  input  logic                                                  in_take,
  input  logic [lsce_pkg::NSENS-1:0][lsce_pkg::SAMPLE_BITS-1:0] in_smp,
  output logic                                                  push,
  output lsce_pkg::q_item_t                                     push_item,
  output lsce_pkg::front_stat_t                                 stat
);
  import lsce_pkg::*;

  logic signed [CAL_W-1:0] cal_r   [0:NSENS-1];
  logic signed [CAL_W-1:0] cal_nxt [0:NSENS-1];
  logic                    v1_r;
  logic                    v2_r;
  q_item_t                 item_r;
  q_item_t                 item_nxt;
  logic signed [NUM_W-1:0] d40;
  logic signed [NUM_W-1:0] d31;
  logic signed [DEN_W-1:0] sum;

  // stage 1: per-sensor dark offset and gain
  always_comb begin
    for (int i = 0; i < NSENS; i++) begin
      cal_nxt[i] = CAL_W'(($signed(CAL_W'(in_smp[i])) - CAL_W'(DARK_TAB[i]))
                          * CAL_W'(GAIN_TAB[i]) + CAL_W'(CAL_BIAS));
    end
  end

  // stage 2: weighted centroid numerator and sum
  always_comb begin
    d40 = NUM_W'(cal_r[4]) - NUM_W'(cal_r[0]);
    d31 = NUM_W'(cal_r[3]) - NUM_W'(cal_r[1]);
    sum = '0;
    for (int i = 0; i < NSENS; i++) begin
      sum = sum + DEN_W'(cal_r[i]);
    end
    item_nxt.num = NUM_W'(-(W_OUTER * d40) - W_INNER * d31);
    item_nxt.den = sum;
    item_nxt.pos = !sum[DEN_W-1] && (sum != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_take;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      for (int i = 0; i < NSENS; i++) cal_r[i] <= cal_nxt[i];
    end
    if (v1_r) begin
      item_r <= item_nxt;
    end
  end

  assign push        = v2_r;
  assign push_item   = item_r;
  assign stat.s1_vld = v1_r;
  assign stat.s2_vld = v2_r;

endmodule

>>> rtl/lsce_queue.sv
module lsce_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  lsce_pkg::q_item_t     push_item,
  input  logic                  pop,
  output lsce_pkg::q_item_t     pop_item,
  output lsce_pkg::queue_stat_t stat
);
  import lsce_pkg::*;

  q_item_t           ent_r [0:QDEPTH-1];
  logic [QPTR_W-1:0] wr_r;
  logic [QPTR_W-1:0] rd_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + QCNT_W'(1);
    if (!push && pop) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  // pointers wrap naturally, depth is a power of two
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + QPTR_W'(1);
      if (pop)  rd_r <= rd_r + QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_r] <= push_item;
  end

  assign pop_item   = ent_r[rd_r];
  assign stat.count = cnt_r;
  assign stat.empty = (cnt_r == '0);

endmodule

>>> rtl/lsce_back.sv
module lsce_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                pop,
  input  lsce_pkg::q_item_t                   pop_item,
  output logic                                res_vld,
  output logic signed [lsce_pkg::OUT_W-1:0]   res_offset,
  output logic                                res_ok
);
  import lsce_pkg::*;

  typedef struct packed {
    logic             pos;
    logic             neg;
    logic             ovf;
    logic [BOT_W-1:0] rem;
    logic [BOT_W-1:0] bot;
    logic [TQ_W-1:0]  dlo;
    logic [TQ_W-1:0]  quo;
  } div_stage_t;

  // one restoring step: bring in the next dividend bit, subtract if it fits
  function automatic div_stage_t div_step(input div_stage_t s);
    div_stage_t       r;
    logic [BOT_W:0]   trial;
    logic             qbit;
    r     = s;
    trial = {s.rem, s.dlo[TQ_W-1]};
    qbit  = (trial >= {1'b0, s.bot});
    if (qbit) begin
      r.rem = BOT_W'(trial - {1'b0, s.bot});
    end else begin
      r.rem = BOT_W'(trial);
    end
    r.dlo = s.dlo << 1;
    r.quo = {s.quo[TQ_W-2:0], qbit};
    return r;
  endfunction

  logic signed [TOP_W-1:0] pnum_r;
  logic signed [TOP_W-1:0] pden_r;
  logic [BOT_W-1:0]        bot1_r;
  logic                    pos1_r;
  logic                    b1_v_r;

  logic signed [TOP_W-1:0] top_nxt;
  logic [TOP_W-1:0]        mag_nxt;
  logic [TOP_W-1:0]        mag2_r;
  logic                    neg2_r;
  logic [BOT_W-1:0]        bot2_r;
  logic                    pos2_r;
  logic                    b2_v_r;

  logic [DVD_W-1:0]        dvd;
  logic [HI_W-1:0]         dvd_hi;
  div_stage_t              stg0_nxt;
  div_stage_t              stg_r   [0:TQ_W];
  logic                    vld_r   [0:TQ_W];

  div_stage_t              fin;
  logic [TQ_W:0]           t_inc;
  logic [TQ_W-1:0]         q_rnd;
  logic [TQ_W-1:0]         q_lim;
  logic [TQ_W-1:0]         q_sat;
  logic [TQ_W-1:0]         q_neg;
  logic signed [OUT_W-1:0] off_nxt;
  logic signed [OUT_W-1:0] off_r;
  logic                    ok_r;
  logic                    out_v_r;

  // B2: signed numerator, magnitude and sign
  always_comb begin
    top_nxt = pnum_r - pden_r;
    mag_nxt = top_nxt[TOP_W-1] ? TOP_W'(-top_nxt) : TOP_W'(top_nxt);
  end

  // B3: scaled dividend; a high part not below the divisor means saturation
  always_comb begin
    dvd           = DVD_W'(mag2_r) << (FRAC_BITS + 1);
    dvd_hi        = HI_W'(dvd >> TQ_W);
    stg0_nxt.pos  = pos2_r;
    stg0_nxt.neg  = neg2_r;
    stg0_nxt.ovf  = (CMP_W'(dvd_hi) >= CMP_W'(bot2_r));
    stg0_nxt.rem  = BOT_W'(dvd_hi);
    stg0_nxt.bot  = bot2_r;
    stg0_nxt.dlo  = dvd[TQ_W-1:0];
    stg0_nxt.quo  = '0;
  end

  // output: round half away from zero, then clamp to the field
  always_comb begin
    fin     = stg_r[TQ_W];
    t_inc   = {1'b0, fin.quo} + (TQ_W+1)'(1);
    q_rnd   = t_inc[TQ_W:1];
    q_lim   = fin.neg ? TQ_W'(MAG_LIM) : TQ_W'(MAG_LIM - 1);
    q_sat   = (fin.ovf || (q_rnd > q_lim)) ? q_lim : q_rnd;
    q_neg   = TQ_W'(0) - q_sat;
    off_nxt = '0;
    if (fin.pos) begin
      off_nxt = fin.neg ? $signed(q_neg[OUT_W-1:0]) : $signed(q_sat[OUT_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      b2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      for (int k = 0; k <= TQ_W; k++) vld_r[k] <= 1'b0;
    end else begin
      b1_v_r   <= pop;
      b2_v_r   <= b1_v_r;
      vld_r[0] <= b2_v_r;
      for (int k = 1; k <= TQ_W; k++) vld_r[k] <= vld_r[k-1];
      out_v_r  <= vld_r[TQ_W];
    end
  end

  always_ff @(posedge clk) begin
    // B1: constant products
    pnum_r   <= TOP_W'(TOP_W'(pop_item.num) * TOP_W'(K_NUM));
    pden_r   <= TOP_W'(TOP_W'(pop_item.den) * TOP_W'(K_BIAS));
    bot1_r   <= BOT_W'(BOT_W'(pop_item.den) * BOT_W'(K_DIV));
    pos1_r   <= pop_item.pos;
    mag2_r   <= mag_nxt;
    neg2_r   <= top_nxt[TOP_W-1];
    bot2_r   <= bot1_r;
    pos2_r   <= pos1_r;
    stg_r[0] <= stg0_nxt;
    for (int k = 1; k <= TQ_W; k++) stg_r[k] <= div_step(stg_r[k-1]);
    off_r    <= off_nxt;
    ok_r     <= fin.pos;
  end

  assign res_vld    = out_v_r;
  assign res_offset = out_v_r ? off_r : '0;
  assign res_ok     = out_v_r ? ok_r : 1'b0;

endmodule

>>> rtl/line_sensor_centroid_error.sv
// Line position from five reflectance sensors.
//
// Input: a beat is taken at a rising edge with start high and busy low; the
// five raw ADC readings on in_sample0..in_sample4 (leftmost to rightmost) are
// sampled at that edge. busy rises only if the queue between the front and
// back halves could overflow, which the back half never lets happen, so in
// practice a new beat may be offered every cycle.
// Output: out_strobe is high for exactly one cycle per input beat, in order,
// once the beat has passed 2 front stages, the queue write and read,
// 3 product/magnitude stages, 17 divider stages and 1 output register.
// out_line_offset is signed Q7.8 mm, rounded and saturated; out_offset_valid
// is low (and the offset zero) when the calibrated sum is not positive.
// Throughput: one beat per cycle; the 17-stage pipelined restoring divider
// retires one quotient per cycle and sets the latency.
// The receiver has no hold-off: each result is there for its one cycle only.
// Reset (rst_n low, synchronous) empties the pipeline and the queue; beats in
// flight are dropped and no strobe follows. There is no configuration.
module line_sensor_centroid_error (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [lsce_pkg::SAMPLE_BITS-1:0]    in_sample0,
  input  logic [lsce_pkg::SAMPLE_BITS-1:0]    in_sample1,
  input  logic [lsce_pkg::SAMPLE_BITS-1:0]    in_sample2,
  input  logic [lsce_pkg::SAMPLE_BITS-1:0]    in_sample3,
  input  logic [lsce_pkg::SAMPLE_BITS-1:0]    in_sample4,
  output logic                                out_strobe,
  output logic signed [lsce_pkg::OUT_W-1:0]   out_line_offset,
  output logic                                out_offset_valid
);
  import lsce_pkg::*;

  logic                                in_take;
  logic [NSENS-1:0][SAMPLE_BITS-1:0]   smp;
  logic                                push;
  q_item_t                             push_item;
  q_item_t                             pop_item;
  logic                                pop;
  front_stat_t                         f_stat;
  queue_stat_t                         q_stat;
  logic [QCNT_W:0]                     occ;

  assign smp = {in_sample4, in_sample3, in_sample2, in_sample1, in_sample0};

  // queue entries plus beats still in the front stages; refuse a beat that
  // might find no room when it arrives
  assign occ     = (QCNT_W+1)'(q_stat.count) + (QCNT_W+1)'(f_stat.s1_vld)
                   + (QCNT_W+1)'(f_stat.s2_vld);
  assign busy    = (occ >= (QCNT_W+1)'(QDEPTH));
  assign in_take = start && !busy;

  // back half never stalls, so drain whenever something is waiting
  assign pop = !q_stat.empty;

  lsce_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_take   (in_take),
    .in_smp    (smp),
    .push      (push),
    .push_item (push_item),
    .stat      (f_stat)
  );

  lsce_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .stat      (q_stat)
  );

  lsce_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop        (pop),
    .pop_item   (pop_item),
    .res_vld    (out_strobe),
    .res_offset (out_line_offset),
    .res_ok     (out_offset_valid)
  );

endmodule

>>> tb/line_sensor_centroid_error_tb.sv
`timescale 1ns / 100ps

module line_sensor_centroid_error_tb;

  import lsce_pkg::SAMPLE_BITS;
  import lsce_pkg::OUT_W;
  import lsce_pkg::NSENS;

  // one set of raw readings, leftmost sensor at index 0
  typedef logic [0:NSENS-1][SAMPLE_BITS-1:0] sample_set_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] line_offset;
    logic                    offset_valid;
  } offset_t;

  // directed row: readings, plus a hand-worked answer where one is given
  typedef struct packed {
    sample_set_t             smp;
    logic                    typed;
    logic signed [OUT_W-1:0] want_off;
    logic                    want_vld;
  } beat_row_t;

  localparam int       DIR_N      = 16;
  localparam int       PHASE_N    = 250;
  localparam int       DRAIN_WAIT = 40;   // well past the end of the pipe
  localparam longint   CAL_ZERO   = 233 * 4096;   // calibrated value at dark, Q.12
  localparam longint   CAL_REF    = 3037;
  localparam longint   OUT_MAX    = 16383;
  localparam longint   OUT_MIN_MAG = 16384;

  // per-sensor dark level and gain divisor
  longint dark_adc [NSENS] = '{235, 230, 226, 234, 240};
  longint cal_div  [NSENS] = '{3154, 3028, 3021, 3068, 3068};

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [SAMPLE_BITS-1:0]  in_sample0, in_sample1, in_sample2, in_sample3, in_sample4;
  logic                    out_strobe;
  logic signed [OUT_W-1:0] out_line_offset;
  logic                    out_offset_valid;

  offset_t pending_offsets [$];
  int      err_cnt = 0;

  // Directed beats. All-zero readings: every sensor below its dark level, sum
  // still positive; worked by hand to 11294. All at dark level: centroid is
  // exactly zero so only the bias term is left, -6986/7703 * 256 -> -232.
  beat_row_t dir_tab [DIR_N] = '{
    '{'{12'd0, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b1, 15'sd11294, 1'b1},
    '{'{12'd235, 12'd230, 12'd226, 12'd234, 12'd240}, 1'b1, -15'sd232, 1'b1},
    '{'{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF}, 1'b0, 15'sd0, 1'b0},
    '{'{12'hFFF, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, 15'sd0, 1'b0},
    '{'{12'd0, 12'hFFF, 12'd0, 12'd0, 12'd0}, 1'b0, 15'sd0, 1'b0},
    '{'{12'd0, 12'd0, 12'hFFF, 12'd0, 12'd0}, 1'b0, 15'sd0, 1'b0},
    '{'{12'd0, 12'd0, 12'd0, 12'hFFF, 12'd0}, 1'b0, 15'sd0, 1'b0},
    '{'{12'd0, 12'd0, 12'd0, 12'd0, 12'hFFF}, 1'b0, 15'sd0, 1'b0},
    '{'{12'hFFF, 12'hFFF, 12'd0, 12'd0, 12'd0}, 1'b0, 15'sd0, 1'b0},
    '{'{12'd0, 12'd0, 12'd0, 12'hFFF, 12'hFFF}, 1'b0, 15'sd0, 1'b0},
    '{'{12'hAAA, 12'hAAA, 12'hAAA, 12'hAAA, 12'hAAA}, 1'b0, 15'sd0, 1'b0},
    '{'{12'h555, 12'h555, 12'h555, 12'h555, 12'h555}, 1'b0, 15'sd0, 1'b0},
    // rightmost sensor far below dark: negative calibrated value taken as is
    '{'{12'd235, 12'd230, 12'd226, 12'd234, 12'd0}, 1'b0, 15'sd0, 1'b0},
    '{'{12'd234, 12'd229, 12'd225, 12'd233, 12'd239}, 1'b0, 15'sd0, 1'b0},
    '{'{12'h800, 12'h800, 12'h800, 12'h800, 12'h800}, 1'b0, 15'sd0, 1'b0},
    '{'{12'h7FF, 12'h7FF, 12'h7FF, 12'h7FF, 12'h7FF}, 1'b0, 15'sd0, 1'b0}
  };

  line_sensor_centroid_error dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_sample0       (in_sample0),
    .in_sample1       (in_sample1),
    .in_sample2       (in_sample2),
    .in_sample3       (in_sample3),
    .in_sample4       (in_sample4),
    .out_strobe       (out_strobe),
    .out_line_offset  (out_line_offset),
    .out_offset_valid (out_offset_valid)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bias-corrected centroid, exact in integers: calibrate each sensor in Q.12,
  // form the weighted numerator and the sum, then round
  // (10000*num - 6986*den) * 2^8 / (7703*den) to nearest, ties away from zero.
  function automatic offset_t centroid_offset(input sample_set_t raw);
    longint            cal [NSENS];
    longint            gain, num, den, top, bot, res;
    longint unsigned   mag, q;
    offset_t           r;
    for (int i = 0; i < NSENS; i++) begin
      gain   = (CAL_REF * 4096 * 2 + cal_div[i]) / (2 * cal_div[i]);
      cal[i] = CAL_ZERO + gain * (longint'(raw[i]) - dark_adc[i]);
    end
    num = -34 * (cal[4] - cal[0]) - 17 * (cal[3] - cal[1]);
    den = cal[0] + cal[1] + cal[2] + cal[3] + cal[4];
    if (den <= 0) begin
      r.line_offset  = '0;
      r.offset_valid = 1'b0;
      return r;
    end
    top = 10000 * num - 6986 * den;
    bot = 7703 * den;
    mag = (top < 0) ? longint'(-top) : longint'(top);
    mag = mag << lsce_pkg::FRAC_BITS;
    q   = (2 * mag + longint'(bot)) / (2 * longint'(bot));
    if (top < 0) begin
      if (q > OUT_MIN_MAG) q = OUT_MIN_MAG;
      res = -longint'(q);
    end else begin
      if (q > OUT_MAX) q = OUT_MAX;
      res = longint'(q);
    end
    r.line_offset  = res[OUT_W-1:0];
    r.offset_valid = 1'b1;
    return r;
  endfunction

  // Random reading sets: one in four line-like (one or two adjacent sensors on the
  // tape over a dim floor), the rest full-range noise, near-dark or extremes.
  function automatic sample_set_t random_set();
    sample_set_t s;
    int          mode, pos, wide;
    mode = $urandom_range(0, 3);
    pos  = $urandom_range(0, NSENS - 1);
    wide = $urandom_range(0, 1);
    for (int i = 0; i < NSENS; i++) begin
      case (mode)
        0: s[i] = SAMPLE_BITS'($urandom);
        1: s[i] = (i == pos || (wide == 1 && i == pos + 1)) ?
                  SAMPLE_BITS'($urandom_range(1800, 4095)) :
                  SAMPLE_BITS'($urandom_range(150, 450));
        2: s[i] = SAMPLE_BITS'($urandom_range(0, 500));
        default: begin
          case ($urandom_range(0, 2))
            0:       s[i] = '0;
            1:       s[i] = '1;
            default: s[i] = SAMPLE_BITS'($urandom);
          endcase
        end
      endcase
    end
    return s;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch, %s: got %0d, want %0d", $time, what, got, want);
    err_cnt++;
  endtask

  // Offer one beat from the falling edge and hold it until a rising edge
  // takes it. busy read here is the value from before the edge.
  task automatic drive_beat(input beat_row_t row);
    offset_t want;
    start      <= 1'b1;
    in_sample0 <= row.smp[0];
    in_sample1 <= row.smp[1];
    in_sample2 <= row.smp[2];
    in_sample3 <= row.smp[3];
    in_sample4 <= row.smp[4];
    do @(posedge clk); while (busy);
    if (row.typed) begin
      want.line_offset  = row.want_off;
      want.offset_valid = row.want_vld;
    end else begin
      want = centroid_offset(row.smp);
    end
    pending_offsets.push_back(want);
    @(negedge clk);
  endtask

  // Sender gap: start low for a few falling edges, odds set per phase.
  task automatic sender_gap(input int pct);
    while ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic drain_pending();
    start <= 1'b0;
    while (pending_offsets.size() != 0) @(negedge clk);
  endtask

  // Results cannot be held off, so every strobe is checked as it comes.
  always @(posedge clk) begin : check_results
    offset_t want;
    if (out_strobe === 1'b1) begin
      if (pending_offsets.size() == 0) begin
        report_mismatch("result beat with nothing pending", out_line_offset, 0);
      end else begin
        want = pending_offsets.pop_front();
        if (out_line_offset !== want.line_offset)
          report_mismatch("line_offset", out_line_offset, want.line_offset);
        if (out_offset_valid !== want.offset_valid)
          report_mismatch("offset_valid", out_offset_valid, want.offset_valid);
      end
    end
  end

  initial begin : stimulus
    int        idle_pct [3];
    beat_row_t row;
    idle_pct   = '{16, 77, 0};
    rst_n      = 1'b0;
    start      = 1'b0;
    in_sample0 = '0;
    in_sample1 = '0;
    in_sample2 = '0;
    in_sample3 = '0;
    in_sample4 = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, back to back
    for (int i = 0; i < DIR_N; i++) drive_beat(dir_tab[i]);
    drain_pending();

    // random part: light sender gaps, then heavy ones, then none at all;
    // the pipe is emptied between phases so the sender sits idle meanwhile
    for (int ph = 0; ph < 3; ph++) begin
      for (int n = 0; n < PHASE_N; n++) begin
        sender_gap(idle_pct[ph]);
        row       = '0;
        row.smp   = random_set();
        drive_beat(row);
      end
      drain_pending();
    end

    start <= 1'b0;
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_cnt == 0)
      $display("line_sensor_centroid_error test passed");
    else
      $display("line_sensor_centroid_error test failed");
    $finish;
  end

  // hang guard for the whole run
  initial begin : watchdog
    #200000;
    $display("line_sensor_centroid_error test failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/lsce_pkg.sv
rtl/lsce_front.sv
rtl/lsce_queue.sv
rtl/lsce_back.sv
rtl/line_sensor_centroid_error.sv
tb/line_sensor_centroid_error_tb.sv
